// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros used by the histogram rtl
// both sample on the rising edge of clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_ON(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/rcbh_pkg.sv -----
// ----------------------------------------------------------------------------
// rcbh_pkg
// types and fixed constants of the colour bin histogram
// ----------------------------------------------------------------------------
`default_nettype none

package rcbh_pkg;

  localparam int PIX_BITS       = 8;
  localparam int KEY_OUT_BITS   = 15;
  localparam int CNT_OUT_BITS   = 16;
  localparam int QUOT_BITS      = 8;
  localparam int NUM_CH         = 3;
  localparam int IN_TDATA_BITS  = 48;
  localparam int IN_TUSER_BITS  = 2;
  localparam int OUT_TDATA_BITS = 72;
  localparam int OUT_TUSER_BITS = 1;
  localparam int CFG_BITS       = 8;

  localparam logic [CFG_BITS-1:0] ALPHA_RESET = 8'd250;

  typedef enum logic [IN_TUSER_BITS-1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef logic [QUOT_BITS-1:0] quot_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ----- rtl/rgb_color_bin_histogram.sv -----
// ----------------------------------------------------------------------------
// rgb_color_bin_histogram
// accumulate or read: an item passes the read, calc, div and output states, and
//   the next item is taken only once its result is in the output register; the
//   averages come from the 3 x 8 steps of the shared divider
// clear: one bin a cycle over all 2^(3*CHANNEL_BITS) bins, then a result
// unused opcode: goes straight to the output state
// reset (synchronous, active high) starts a clearing pass over all bins; no
//   item is taken until it ends, config writes are taken throughout
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgb_color_bin_histogram #(
  parameter int CHANNEL_BITS = 5,
  parameter int COUNT_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pixel_alpha, pixel_red, pixel_green, pixel_blue, bin_index, zero pad
  input  logic [rcbh_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
  // opcode
  input  logic [rcbh_pkg::IN_TUSER_BITS-1:0]    s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // bin_key, bin_count, avg_red, avg_green, avg_blue, total_opaque, zero pad
  output logic [rcbh_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
  // counted
  output logic [rcbh_pkg::OUT_TUSER_BITS-1:0]   m_axis_tuser,
  // alpha threshold write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rcbh_pkg::CFG_BITS-1:0]         cfg_data
);
  import rcbh_pkg::*;

  // bin store geometry
  localparam int IDX_BITS = 3 * CHANNEL_BITS;
  localparam int NUM_BINS = 1 << IDX_BITS;
  localparam int SUM_BITS = COUNT_BITS + QUOT_BITS;
  localparam logic [31:0] OUT_MAX = 32'((64'd1 << CNT_OUT_BITS) - 64'd1);

  // one bin: pixel count and the three channel sums
  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [SUM_BITS-1:0]   red;
    logic [SUM_BITS-1:0]   green;
    logic [SUM_BITS-1:0]   blue;
  } entry_t;

  // sequencer
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CALC  = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [IDX_BITS-1:0]    clr_addr;
  logic                   clr_reply;
  logic [CFG_BITS-1:0]    threshold;
  logic [COUNT_BITS-1:0]  total;

  // item held while it is worked on
  opcode_t                op_q;
  logic [IDX_BITS-1:0]    key_q;
  logic                   counted_q;
  logic [PIX_BITS-1:0]    red_q;
  logic [PIX_BITS-1:0]    green_q;
  logic [PIX_BITS-1:0]    blue_q;
  logic [COUNT_BITS-1:0]  cnt_q;

  // bin store
  entry_t                 mem [NUM_BINS];
  entry_t                 rd_q;
  entry_t                 upd;
  entry_t                 mem_wdata;
  logic [IDX_BITS-1:0]    mem_waddr;
  logic                   mem_we;
  logic                   bump;

  // divider
  logic [SUM_BITS-1:0]    div_sums [NUM_CH];
  div_status_t            div_st;
  quot_t                  div_quot [NUM_CH];

  // output register
  logic                   m_valid;
  logic [OUT_TDATA_BITS-1:0] m_data;
  logic [OUT_TUSER_BITS-1:0] m_user;

  // input unpacking
  logic [PIX_BITS-1:0]     in_alpha;
  logic [PIX_BITS-1:0]     in_red;
  logic [PIX_BITS-1:0]     in_green;
  logic [PIX_BITS-1:0]     in_blue;
  logic [KEY_OUT_BITS-1:0] in_index;
  opcode_t                 in_op;
  logic [IDX_BITS-1:0]     pix_key;
  logic                    in_xfer;
  logic                    out_load;
  logic                    res_bin;

  function automatic logic [CNT_OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > OUT_MAX) ? {CNT_OUT_BITS{1'b1}} : w[CNT_OUT_BITS-1:0];
  endfunction

  assign in_alpha = s_axis_tdata[7:0];
  assign in_red   = s_axis_tdata[15:8];
  assign in_green = s_axis_tdata[23:16];
  assign in_blue  = s_axis_tdata[31:24];
  assign in_index = s_axis_tdata[46:32];
  assign in_op    = opcode_t'(s_axis_tuser);

  // bin of the pixel: top bits of red, green, blue
  assign pix_key = {in_red[PIX_BITS-1 -: CHANNEL_BITS],
                    in_green[PIX_BITS-1 -: CHANNEL_BITS],
                    in_blue[PIX_BITS-1 -: CHANNEL_BITS]};

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // a full bin is left alone, sums included, so its average stays right
  assign bump = counted_q && (rd_q.cnt != {COUNT_BITS{1'b1}});

  always_comb begin
    upd = rd_q;
    if (bump) begin
      upd.cnt   = rd_q.cnt + 1'b1;
      upd.red   = rd_q.red   + SUM_BITS'(red_q);
      upd.green = rd_q.green + SUM_BITS'(green_q);
      upd.blue  = rd_q.blue  + SUM_BITS'(blue_q);
    end
  end

  // single write port, shared by the clearing pass and the bin update
  assign mem_we    = (state == S_CLEAR) || ((state == S_CALC) && bump);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : key_q;
  assign mem_wdata = (state == S_CLEAR) ? '0 : upd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_READ) begin
      rd_q <= mem[key_q];
    end
  end

  // averages come from the bin as it stands after the update
  assign div_sums[0] = upd.red;
  assign div_sums[1] = upd.green;
  assign div_sums[2] = upd.blue;

  rcbh_div_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_CALC),
    .cnt    (upd.cnt),
    .sum_in (div_sums),
    .status (div_st),
    .quot   (div_quot)
  );

  assign out_load = (state == S_OUT) && (!m_valid || m_axis_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == {IDX_BITS{1'b1}}) begin
          state_next = clr_reply ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            OP_ACCUM, OP_READ: state_next = S_READ;
            OP_CLEAR:          state_next = S_CLEAR;
            default:           state_next = S_OUT;
          endcase
        end
      end
      S_READ:  state_next = S_CALC;
      S_CALC:  state_next = S_DIV;
      S_DIV: begin
        if (div_st.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      threshold <= ALPHA_RESET;
      total     <= '0;
      m_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
        total    <= '0;
        if (clr_addr == {IDX_BITS{1'b1}}) begin
          clr_reply <= 1'b0;
        end
      end
      if (in_xfer && (in_op == OP_CLEAR)) begin
        clr_addr  <= '0;
        clr_reply <= 1'b1;
      end
      // the total keeps counting when the bin itself is full
      if ((state == S_CALC) && counted_q && (total != {COUNT_BITS{1'b1}})) begin
        total <= total + 1'b1;
      end
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // item payload, captured at the transfer; the updated bin count, in the calc state
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q      <= in_op;
      key_q     <= (in_op == OP_READ) ? IDX_BITS'(in_index) : pix_key;
      counted_q <= (in_op == OP_ACCUM) && (in_alpha >= threshold);
      red_q     <= in_red;
      green_q   <= in_green;
      blue_q    <= in_blue;
    end
    if (state == S_CALC) begin
      cnt_q <= upd.cnt;
    end
  end

  // result assembly: bin fields only for accumulate and read
  assign res_bin = (op_q == OP_ACCUM) || (op_q == OP_READ);

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (res_bin) begin
        m_data <= {1'b0, sat_out(total), div_quot[2], div_quot[1], div_quot[0],
                   sat_out(cnt_q), KEY_OUT_BITS'(key_q)};
        m_user <= counted_q;
      end else begin
        m_data <= {1'b0, sat_out(total), {(OUT_TDATA_BITS-CNT_OUT_BITS-1){1'b0}}};
        m_user <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign m_axis_tuser  = m_user;

  // the divider only runs while the sequencer waits on it
  `ASSERT_ON(a_div_in_div_state, (div_st.busy || div_st.done) |-> (state == S_DIV))
  // the store is written only by the clearing pass or a bin update
  `ASSERT_ON(a_write_source, mem_we |-> ((state == S_CLEAR) || (state == S_CALC)))
  // a transfer always starts work on the item
  `ASSERT_ON(a_xfer_leaves_idle, in_xfer |=> (state != S_IDLE))
  // no item is taken during the clearing pass
  `ASSERT_ALWAYS(a_no_xfer_in_clear, (state == S_CLEAR) |-> !s_axis_tready)

endmodule

`default_nettype wire

// ----- rtl/rcbh_div_unit.sv -----
// ----------------------------------------------------------------------------
// rcbh_div_unit
// shared restoring divider: three channel sums over one count, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rcbh_div_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [COUNT_BITS-1:0]                         cnt,
  input  logic [COUNT_BITS+rcbh_pkg::QUOT_BITS-1:0]     sum_in [rcbh_pkg::NUM_CH],
  output rcbh_pkg::div_status_t                         status,
  output rcbh_pkg::quot_t                               quot   [rcbh_pkg::NUM_CH]
);
  import rcbh_pkg::*;

  localparam int SUM_BITS  = COUNT_BITS + QUOT_BITS;
  localparam int STEP_BITS = $clog2(QUOT_BITS);
  localparam int CH_BITS   = $clog2(NUM_CH);
  localparam logic [STEP_BITS-1:0] STEP_TOP = STEP_BITS'(QUOT_BITS - 1);
  localparam logic [CH_BITS-1:0]   CH_LAST  = CH_BITS'(NUM_CH - 1);

  logic                  busy;
  logic                  done;
  logic [CH_BITS-1:0]    ch;
  logic [STEP_BITS-1:0]  step;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [SUM_BITS-1:0]   div_sh;
  logic [SUM_BITS-1:0]   rem [NUM_CH];
  quot_t                 quot_q [NUM_CH];

  logic [SUM_BITS-1:0]   first_sh;
  logic [SUM_BITS-1:0]   reload_sh;
  logic [SUM_BITS-1:0]   diff;
  logic                  ge;

  assign first_sh  = SUM_BITS'(cnt) << (QUOT_BITS - 1);
  assign reload_sh = SUM_BITS'(cnt_q) << (QUOT_BITS - 1);

  // the one compare and subtract shared by all channels and steps
  assign ge   = (cnt_q != '0) && (rem[ch] >= div_sh);
  assign diff = rem[ch] - div_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ch   <= '0;
      step <= '0;
    end else begin
      // pulse after the last step of the last channel
      done <= !start && busy && (step == '0) && (ch == CH_LAST);
      if (start) begin
        busy <= 1'b1;
        ch   <= '0;
        step <= STEP_TOP;
      end else if (busy) begin
        if (step == '0) begin
          if (ch == CH_LAST) begin
            busy <= 1'b0;
          end else begin
            ch   <= ch + 1'b1;
            step <= STEP_TOP;
          end
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_q  <= cnt;
      div_sh <= first_sh;
      rem    <= sum_in;
    end else if (busy) begin
      if (ge) begin
        rem[ch] <= diff;
      end
      quot_q[ch] <= {quot_q[ch][QUOT_BITS-2:0], ge};
      if (step == '0) begin
        div_sh <= reload_sh;
      end else begin
        div_sh <= div_sh >> 1;
      end
    end
  end

  assign status = '{busy: busy, done: done};
  assign quot   = quot_q;

endmodule

`default_nettype wire

// ----- bench/rgb_color_bin_histogram_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_bin_histogram_test
// self-checking bench for the colour bin histogram: pixels, bin reads, clears
// and no-ops are streamed in with random bursts and gaps, results are drained
// against a stall pattern, random stalls or no stalls, and compared with a bin
// store kept inside the bench

module rgb_color_bin_histogram_test;
  import rcbh_pkg::*;

  localparam int NUM_BINS   = 32768;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam int RUN_LIMIT  = 3000000;
  localparam int DRAIN_WAIT = 40;

  // one result as the bench sees it, counted comes from tuser
  typedef struct packed {
    logic [15:0] total;
    logic [7:0]  avg_b;
    logic [7:0]  avg_g;
    logic [7:0]  avg_r;
    logic [15:0] count;
    logic [14:0] key;
    logic        counted;
  } bin_report_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // pixel_alpha, pixel_red, pixel_green, pixel_blue, bin_index, zero pad
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
  // opcode
  logic [IN_TUSER_BITS-1:0]  s_axis_tuser  = OP_NOP;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // bin_key, bin_count, avg_red, avg_green, avg_blue, total_opaque, zero pad
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  // counted
  logic [OUT_TUSER_BITS-1:0] m_axis_tuser;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_BITS-1:0]       cfg_data  = '0;

  // histogram as the bench expects it
  logic [15:0] bin_count_mem [NUM_BINS];
  logic [23:0] red_sum_mem   [NUM_BINS];
  logic [23:0] green_sum_mem [NUM_BINS];
  logic [23:0] blue_sum_mem  [NUM_BINS];
  logic [15:0] opaque_total;
  logic [7:0]  alpha_threshold = ALPHA_RESET;

  bin_report_t expected_reports [$];
  int          fail_count  = 0;
  int unsigned cycle_count = 0;

  // sender burst control
  int burst_left = 0;
  int burst_max  = 8;
  int gap_max    = 4;

  // receiver stall control
  rx_mode_t    rx_mode    = RX_PATTERN;
  logic [15:0] rx_pattern = 16'hB5AD;
  logic [3:0]  rx_pos     = '0;

  rgb_color_bin_histogram dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // expected histogram behaviour
  // ---------------------------------------------------------------------------

  function automatic void clear_histogram();
    for (int i = 0; i < NUM_BINS; i++) begin
      bin_count_mem[i] = '0;
      red_sum_mem[i]   = '0;
      green_sum_mem[i] = '0;
      blue_sum_mem[i]  = '0;
    end
    opaque_total = '0;
  endfunction

  // truncated mean of one channel, an empty bin reads as zero
  function automatic logic [7:0] bin_average(logic [23:0] sum, logic [15:0] cnt);
    logic [23:0] quot;
    if (cnt == 0) return 8'd0;
    quot = sum / cnt;
    return (quot > 24'd255) ? 8'd255 : quot[7:0];
  endfunction

  function automatic bin_report_t report_for_bin(bin_report_t rep, logic [14:0] key);
    rep.key   = key;
    rep.count = bin_count_mem[key];
    rep.avg_r = bin_average(red_sum_mem[key], bin_count_mem[key]);
    rep.avg_g = bin_average(green_sum_mem[key], bin_count_mem[key]);
    rep.avg_b = bin_average(blue_sum_mem[key], bin_count_mem[key]);
    rep.total = opaque_total;
    return rep;
  endfunction

  function automatic bin_report_t predict_bin_report(opcode_t op, logic [7:0] px_a,
                                                     logic [7:0] px_r, logic [7:0] px_g,
                                                     logic [7:0] px_b, logic [14:0] idx);
    bin_report_t rep;
    logic [14:0] key;
    rep = '0;
    case (op)
      OP_ACCUM: begin
        // top five bits of each channel pick the bin
        key = {px_r[7:3], px_g[7:3], px_b[7:3]};
        if (px_a >= alpha_threshold) begin
          rep.counted = 1'b1;
          // a full bin is frozen, sums included
          if (bin_count_mem[key] != COUNT_MAX) begin
            bin_count_mem[key] = bin_count_mem[key] + 16'd1;
            red_sum_mem[key]   = red_sum_mem[key] + px_r;
            green_sum_mem[key] = green_sum_mem[key] + px_g;
            blue_sum_mem[key]  = blue_sum_mem[key] + px_b;
          end
          if (opaque_total != COUNT_MAX) opaque_total = opaque_total + 16'd1;
        end
        rep = report_for_bin(rep, key);
      end
      OP_READ:  rep = report_for_bin(rep, idx);
      OP_CLEAR: clear_histogram();
      default:  rep.total = opaque_total;
    endcase
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transfer, bursts and gaps decided here
  task automatic send_item(input opcode_t op, input logic [7:0] px_a, input logic [7:0] px_r,
                           input logic [7:0] px_g, input logic [7:0] px_b,
                           input logic [14:0] idx);
    bin_report_t want;
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, idx, px_b, px_g, px_r, px_a};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    want = predict_bin_report(op, px_a, px_r, px_g, px_b, idx);
    expected_reports = {expected_reports, want};
  endtask

  // stop sending and wait until every result is back
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    alpha_threshold = value;
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic string show_report(bin_report_t r);
    return $sformatf("counted=%0d key=%04h count=%0d avg=%0d/%0d/%0d total=%0d",
                     r.counted, r.key, r.count, r.avg_r, r.avg_g, r.avg_b, r.total);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // store starts empty, no-op shows the zero total
  task automatic test_empty_bins();
    send_item(OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h0000);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 15'h7FFF);
    send_item(OP_NOP, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 15'h2AAA);
  endtask

  // alpha at, above and below the reset threshold, averages and reads
  task automatic test_accumulate_and_skip();
    send_item(OP_ACCUM, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h0000);
    send_item(OP_ACCUM, 8'd250, 8'h00, 8'h00, 8'h00, 15'h7FFF);
    send_item(OP_ACCUM, 8'd249, 8'd8, 8'd16, 8'd24, 15'h5555);
    send_item(OP_ACCUM, 8'h00, 8'hFF, 8'h00, 8'hFF, 15'h0000);
    send_item(OP_ACCUM, 8'hFF, 8'h07, 8'h07, 8'h07, 15'h1234);
    send_item(OP_ACCUM, 8'hFF, 8'hA5, 8'h5A, 8'hC3, 15'h0F0F);
    send_item(OP_ACCUM, 8'hFE, 8'hA0, 8'h58, 8'hC7, 15'h7000);
    send_item(OP_ACCUM, 8'hFF, 8'hFF, 8'h00, 8'hAA, 15'h0000);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 15'h0000);
    send_item(OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, {5'h14, 5'h0B, 5'h18});
    send_item(OP_NOP, 8'hFF, 8'h00, 8'hFF, 8'h00, 15'h7FFF);
  endtask

  // clear empties every bin and the total
  task automatic test_clear();
    send_item(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 15'h0000);
    send_item(OP_NOP, 8'h00, 8'h00, 8'h00, 8'h00, 15'h0000);
    send_item(OP_ACCUM, 8'hFF, 8'h81, 8'h42, 8'h24, 15'h0000);
  endtask

  // threshold at both ends of its range
  task automatic test_alpha_extremes();
    finish_phase();
    write_threshold(8'd0);
    send_item(OP_ACCUM, 8'h00, 8'h10, 8'h20, 8'h30, 15'h0000);
    send_item(OP_ACCUM, 8'h80, 8'h17, 8'h27, 8'h37, 15'h0000);
    finish_phase();
    write_threshold(8'd255);
    send_item(OP_ACCUM, 8'hFE, 8'h10, 8'h20, 8'h30, 15'h0000);
    send_item(OP_ACCUM, 8'hFF, 8'h11, 8'h21, 8'h31, 15'h0000);
  endtask

  // phases of mostly well-formed traffic into a handful of busy bins
  task automatic test_random_traffic();
    logic [14:0] hot_bins [8];
    logic [14:0] key;
    logic [7:0]  px_a;
    int          plan [6];
    int          pick;
    int          near;
    int          clears_left;
    plan = '{0, 255, 128, 1, -1, 250};
    clears_left = 8;
    for (int ph = 0; ph < 6; ph++) begin
      finish_phase();
      write_threshold(plan[ph] < 0 ? 8'($urandom_range(0, 255)) : 8'(plan[ph]));
      if (ph == 0) begin
        // one stretch with no idling on either side
        gap_max = 0;
        burst_max = 40;
        rx_mode <= RX_ALWAYS;
      end else begin
        case ($urandom_range(0, 2))
          0:       gap_max = 0;
          1:       gap_max = 4;
          default: gap_max = 35;
        endcase
        burst_max = $urandom_range(1, 24);
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        rx_pattern <= 16'($urandom) | 16'h0001;
      end
      foreach (hot_bins[i]) hot_bins[i] = 15'($urandom);
      for (int n = 0; n < 170; n++) begin
        pick = $urandom_range(0, 99);
        key  = hot_bins[$urandom_range(0, 7)];
        if ($urandom_range(0, 1) == 0) begin
          // alpha close to the threshold, both sides of it
          near = int'(alpha_threshold) + int'($urandom_range(0, 4)) - 2;
          px_a = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : 8'(near);
        end else begin
          px_a = 8'($urandom);
        end
        if (pick < 60) begin
          send_item(OP_ACCUM, px_a, {key[14:10], 3'($urandom)}, {key[9:5], 3'($urandom)},
                    {key[4:0], 3'($urandom)}, 15'($urandom));
        end else if (pick < 85) begin
          send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), key);
        end else if (pick < 93) begin
          send_item(OP_ACCUM, px_a, 8'($urandom), 8'($urandom), 8'($urandom),
                    15'($urandom));
        end else if (pick < 98) begin
          send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    15'($urandom));
        end else if (pick == 99 && clears_left > 0) begin
          clears_left--;
          send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    15'($urandom));
        end else begin
          send_item(OP_NOP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    15'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_pos <= rx_pos + 4'd1;
    case (rx_mode)
      RX_ALWAYS:  m_axis_tready <= 1'b1;
      RX_PATTERN: m_axis_tready <= rx_pattern[rx_pos];
      default:    m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // result checking, one expectation per output transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    bin_report_t got;
    bin_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.counted = m_axis_tuser[0];
      got.key     = m_axis_tdata[14:0];
      got.count   = m_axis_tdata[30:15];
      got.avg_r   = m_axis_tdata[38:31];
      got.avg_g   = m_axis_tdata[46:39];
      got.avg_b   = m_axis_tdata[54:47];
      got.total   = m_axis_tdata[70:55];
      if (expected_reports.size() == 0) begin
        note_failure({"result with nothing expected: ", show_report(got)});
      end else begin
        want = expected_reports.pop_front();
        if (got.counted !== want.counted || got.key !== want.key ||
            got.count !== want.count || got.avg_r !== want.avg_r ||
            got.avg_g !== want.avg_g || got.avg_b !== want.avg_b ||
            got.total !== want.total)
          note_failure({"expected ", show_report(want), " got ", show_report(got)});
      end
    end
  end

  // run limit, covers the clearing pass after reset and every clear
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_histogram();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_bins();
    test_accumulate_and_skip();
    test_clear();
    test_alpha_extremes();
    test_random_traffic();

    finish_phase();
    // let any stray transfer show up before the verdict
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_reports.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_reports.size()));

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rcbh_pkg.sv
rtl/rcbh_div_unit.sv
rtl/rgb_color_bin_histogram.sv
bench/rgb_color_bin_histogram_test.sv
